// File: hdl/ctab_pkg.sv
// ----------------------------------------------------------------------------
// ctab_pkg
// Shared types, op codes and helpers for the cigar to aligned blocks block.
// ----------------------------------------------------------------------------
package ctab_pkg;

	localparam int OpW    = 4;
	localparam int LenW   = 28;
	localparam int PosW   = 32;
	localparam int QDepth = 4;
	localparam int QPtrW  = $clog2(QDepth);
	localparam int QCntW  = $clog2(QDepth + 1);

	localparam logic [OpW-1:0] OP_MATCH = 4'd0;
	localparam logic [OpW-1:0] OP_DEL   = 4'd2;
	localparam logic [OpW-1:0] OP_SKIP  = 4'd3;
	localparam logic [OpW-1:0] OP_SOFT  = 4'd4;
	localparam logic [OpW-1:0] OP_HARD  = 4'd5;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_MATCH,
		KIND_DEL,
		KIND_CLIP
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic              after_skip;
		logic              first;
		logic              last;
		logic [LenW-1:0]   len;
		logic [LenW-1:0]   skip_len;
		logic [LenW:0]     skip_sum;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef struct packed {
		logic [PosW-1:0] block_start;
		logic [PosW-1:0] block_length;
		logic            read_done;
		logic            read_clipped;
		logic            no_blocks;
	} res_t;

	function automatic logic [PosW-1:0] sat_add(input logic [PosW-1:0] a,
	                                            input logic [PosW-1:0] b);
		logic [PosW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[PosW] ? {PosW{1'b1}} : s[PosW-1:0];
	endfunction

endpackage

// File: hdl/ctab_front.sv
// ----------------------------------------------------------------------------
// ctab_front
// Accepts cigar words, classifies the op and tracks a preceding skip.
// ----------------------------------------------------------------------------
module ctab_front import ctab_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [OpW-1:0]   op_code,
	input  logic [LenW-1:0]  op_length,
	input  logic             first_op,
	input  logic             last_op,
	input  logic             q_full,
	output logic             push,
	output item_t            push_item
);

	logic            prev_skip_q;
	logic [LenW-1:0] prev_len_q;
	kind_t           kind;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		unique case (op_code) inside
			OP_MATCH:         kind = KIND_MATCH;
			OP_DEL:           kind = KIND_DEL;
			OP_SOFT, OP_HARD: kind = KIND_CLIP;
			default:          kind = KIND_NONE;
		endcase
	end

	always_comb begin
		push_item.kind       = kind;
		push_item.after_skip = prev_skip_q && !first_op;
		push_item.first      = first_op;
		push_item.last       = last_op;
		push_item.len        = op_length;
		push_item.skip_len   = prev_len_q;
		push_item.skip_sum   = {1'b0, prev_len_q} + {1'b0, op_length};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_skip_q <= 1'b0;
			prev_len_q  <= '0;
		end else if (push) begin
			prev_skip_q <= (op_code == OP_SKIP) && !last_op;
			prev_len_q  <= op_length;
		end
	end

endmodule

// File: hdl/ctab_queue.sv
// ----------------------------------------------------------------------------
// ctab_queue
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module ctab_queue import ctab_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  item_t     push_item,
	input  logic      pop,
	output item_t     head,
	output q_status_t status
);

	item_t            mem_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QCntW-1:0] count_q;

	assign head         = mem_q[rd_ptr_q];
	assign status.full  = (count_q == QCntW'(QDepth));
	assign status.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: hdl/ctab_back.sv
// ----------------------------------------------------------------------------
// ctab_back
// Holds the open block, applies each item and drives the result register.
// ----------------------------------------------------------------------------
module ctab_back import ctab_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  item_t     head,
	input  logic      q_empty,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_stall,
	output res_t      out_res
);

	logic            block_open_q;
	logic [PosW-1:0] open_start_q;
	logic [PosW-1:0] open_len_q;
	logic [PosW-1:0] open_end_q;
	logic            clip_q;
	logic            out_valid_q;
	res_t            out_q;
	logic            pend_valid_q;
	res_t            pend_q;

	logic            bo;
	logic            clip_eff;
	logic            nxt_open;
	logic [PosW-1:0] nxt_start;
	logic [PosW-1:0] nxt_len;
	logic [PosW-1:0] nxt_end;
	logic            nxt_clip;
	logic            split;
	logic            has_res;
	logic            out_free;
	logic [PosW-1:0] len_ext;
	logic [PosW-1:0] add_len;
	logic [PosW-1:0] add_end;
	logic [PosW-1:0] skip_start;
	logic [PosW-1:0] skip_end;
	res_t            res_a;
	res_t            res_f;

	assign len_ext    = PosW'(head.len);
	assign add_len    = sat_add(open_len_q, len_ext);
	assign add_end    = sat_add(open_end_q, len_ext);
	assign skip_start = sat_add(open_end_q, PosW'(head.skip_len));
	assign skip_end   = sat_add(open_end_q, PosW'(head.skip_sum));

	always_comb begin
		bo        = block_open_q && !head.first;
		clip_eff  = clip_q && !head.first;
		nxt_open  = bo;
		nxt_start = open_start_q;
		nxt_len   = open_len_q;
		nxt_end   = open_end_q;
		nxt_clip  = clip_eff || (head.kind == KIND_CLIP);
		split     = 1'b0;
		case (head.kind)
			KIND_MATCH: begin
				if (!bo) begin
					nxt_open  = 1'b1;
					nxt_start = '0;
					nxt_len   = len_ext;
					nxt_end   = len_ext;
				end else if (head.after_skip) begin
					split     = 1'b1;
					nxt_start = skip_start;
					nxt_len   = len_ext;
					nxt_end   = skip_end;
				end else begin
					nxt_len = add_len;
					nxt_end = add_end;
				end
			end
			KIND_DEL: begin
				if (bo) begin
					nxt_len = add_len;
					nxt_end = add_end;
				end
			end
			default: begin
			end
		endcase

		res_a.block_start  = open_start_q;
		res_a.block_length = open_len_q;
		res_a.read_done    = 1'b0;
		res_a.read_clipped = clip_eff;
		res_a.no_blocks    = 1'b0;

		res_f.block_start  = nxt_open ? nxt_start : '0;
		res_f.block_length = nxt_open ? nxt_len : '0;
		res_f.read_done    = 1'b1;
		res_f.read_clipped = nxt_clip;
		res_f.no_blocks    = !nxt_open;
	end

	assign has_res   = split || head.last;
	assign out_free  = !out_valid_q || !out_stall;
	assign pop       = !q_empty && !pend_valid_q && (out_free || !has_res);
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (pend_valid_q) begin
				out_q <= pend_q;
			end else if (pop && split) begin
				out_q <= res_a;
			end else if (pop && head.last) begin
				out_q <= res_f;
			end
		end
		if (pop) begin
			pend_q       <= res_f;
			open_start_q <= nxt_start;
			open_len_q   <= nxt_len;
			open_end_q   <= nxt_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_open_q <= 1'b0;
			clip_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				if (pend_valid_q) begin
					out_valid_q  <= 1'b1;
					pend_valid_q <= 1'b0;
				end else begin
					out_valid_q <= pop && has_res;
				end
			end
			if (pop) begin
				pend_valid_q <= split && head.last;
				block_open_q <= nxt_open && !head.last;
				clip_q       <= nxt_clip && !head.last;
			end
		end
	end

endmodule

// File: hdl/cigar_to_aligned_blocks.sv
// ----------------------------------------------------------------------------
// cigar_to_aligned_blocks
// Turns a stream of cigar words into aligned blocks relative to read start.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries one cigar op per transaction:
// op_code, op_length and the first_op / last_op marks of a read.
// Output channel (out_valid / out_stall) carries one aligned block per
// transaction with read_done on the final block of a read, read_clipped
// and no_blocks for a read that ended without any block.
// A front stage classifies each op and remembers a preceding skip, a
// four-entry queue decouples it from the back stage, which holds the open
// block and keeps start, length and end as saturating 32-bit values.
// Input ops pass through the queue; the back stage registers each result.
// Throughput is one op per cycle while no stall holds the flow; a match
// after a skip on the last op of a read yields two results, and no op is
// popped until the second one reaches the output register. While
// out_stall is high results hold and the queue fills; in_stall rises once
// the queue is full. Reset empties the queue, closes the open block and
// clears out_valid; no result is pending after reset.
// ----------------------------------------------------------------------------
module cigar_to_aligned_blocks import ctab_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [OpW-1:0]   op_code,
	input  logic [LenW-1:0]  op_length,
	input  logic             first_op,
	input  logic             last_op,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [PosW-1:0]  block_start,
	output logic [PosW-1:0]  block_length,
	output logic             read_done,
	output logic             read_clipped,
	output logic             no_blocks
);

	logic      push;
	item_t     push_item;
	logic      pop;
	item_t     head;
	q_status_t q_status;
	res_t      out_res;

	ctab_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op_code   (op_code),
		.op_length (op_length),
		.first_op  (first_op),
		.last_op   (last_op),
		.q_full    (q_status.full),
		.push      (push),
		.push_item (push_item)
	);

	ctab_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.status    (q_status)
	);

	ctab_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_empty   (q_status.empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	assign block_start  = out_res.block_start;
	assign block_length = out_res.block_length;
	assign read_done    = out_res.read_done;
	assign read_clipped = out_res.read_clipped;
	assign no_blocks    = out_res.no_blocks;

endmodule
